>>> rtl/fpst_pkg.sv
// Shared constants, codes and types for the Fenwick prefix-sum table.
package fpst_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CHAIN_W     = ADDR_W + 1;
  localparam int POS_W       = 10;
  localparam int SUM_W       = 64;
  localparam int WIDE_W      = (POS_W > CHAIN_W) ? POS_W : CHAIN_W;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [SUM_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } res_t;

endpackage

>>> rtl/fpst_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module fpst_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/fpst_seq.sv
// Sequencer: clearing pass, chain walk over the table, and prefix accumulation.
module fpst_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_take,
  input  logic                       in_op,
  input  logic [fpst_pkg::POS_W-1:0] in_pos,
  input  logic [fpst_pkg::SUM_W-1:0] in_inc,
  input  logic                       out_free,
  input  logic [fpst_pkg::SUM_W-1:0] rd_data,
  output logic                       idle,
  output logic                       clearing,
  output fpst_pkg::mem_req_t         mem_req,
  output fpst_pkg::res_t             res
);

  fpst_pkg::seq_state_t              state_r, state_nxt;
  logic                              op_r, op_nxt;
  logic [fpst_pkg::CHAIN_W-1:0]      cur_r, cur_nxt;
  logic [fpst_pkg::SUM_W-1:0]        inc_r, inc_nxt;
  logic [fpst_pkg::SUM_W-1:0]        acc_r, acc_nxt;
  logic [fpst_pkg::ADDR_W-1:0]       clr_r, clr_nxt;

  logic [fpst_pkg::WIDE_W-1:0]       pos_wide;
  logic [fpst_pkg::CHAIN_W-1:0]      start_pos;
  logic [fpst_pkg::CHAIN_W-1:0]      up_next;
  logic [fpst_pkg::CHAIN_W-1:0]      down_next;
  logic                              beyond;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpst_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    cur_r <= cur_nxt;
    inc_r <= inc_nxt;
    acc_r <= acc_nxt;
  end

  // Chain steps: climb adds the lowest set bit, descent clears it.
  assign pos_wide  = fpst_pkg::WIDE_W'(in_pos);
  assign beyond    = (pos_wide >= fpst_pkg::WIDE_W'(fpst_pkg::TABLE_DEPTH));
  assign up_next   = cur_r + (cur_r & (~cur_r + fpst_pkg::CHAIN_W'(1)));
  assign down_next = cur_r & (cur_r - fpst_pkg::CHAIN_W'(1));

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cur_nxt   = cur_r;
    inc_nxt   = inc_r;
    acc_nxt   = acc_r;
    clr_nxt   = clr_r;
    mem_req   = '0;
    res.valid = 1'b0;
    res.sum   = acc_r;
    idle      = 1'b0;
    clearing  = 1'b0;
    start_pos = '0;

    case (state_r)
      fpst_pkg::ST_CLEAR: begin
        clearing      = 1'b1;
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = '0;
        clr_nxt       = clr_r + fpst_pkg::ADDR_W'(1);
        if (clr_r == fpst_pkg::ADDR_W'(fpst_pkg::TABLE_DEPTH - 1)) begin
          state_nxt = fpst_pkg::ST_IDLE;
        end
      end

      fpst_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (beyond) begin
          start_pos = fpst_pkg::CHAIN_W'(fpst_pkg::TABLE_DEPTH - 1);
        end else begin
          start_pos = fpst_pkg::CHAIN_W'(pos_wide);
        end
        if (in_take) begin
          op_nxt  = in_op;
          inc_nxt = in_inc;
          acc_nxt = '0;
          cur_nxt = start_pos;
          if (in_op == fpst_pkg::OP_QUERY) begin
            if (in_pos == '0) begin
              state_nxt = fpst_pkg::ST_EMIT;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = start_pos[fpst_pkg::ADDR_W-1:0];
              state_nxt     = fpst_pkg::ST_WALK;
            end
          end else if (in_pos != '0 && !beyond) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = start_pos[fpst_pkg::ADDR_W-1:0];
            state_nxt     = fpst_pkg::ST_WALK;
          end
        end
      end

      fpst_pkg::ST_WALK: begin
        // Read data for cur_r is here; issue the next chain read alongside.
        if (op_r == fpst_pkg::OP_ADD) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = cur_r[fpst_pkg::ADDR_W-1:0];
          mem_req.wdata = rd_data + inc_r;
          if (up_next < fpst_pkg::CHAIN_W'(fpst_pkg::TABLE_DEPTH)) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = up_next[fpst_pkg::ADDR_W-1:0];
            cur_nxt       = up_next;
          end else begin
            state_nxt = fpst_pkg::ST_IDLE;
          end
        end else begin
          acc_nxt = acc_r + rd_data;
          if (down_next != '0) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = down_next[fpst_pkg::ADDR_W-1:0];
            cur_nxt       = down_next;
          end else begin
            state_nxt = fpst_pkg::ST_EMIT;
          end
        end
      end

      fpst_pkg::ST_EMIT: begin
        // Hold the sum until the output register can take it.
        res.valid = out_free;
        if (out_free) begin
          state_nxt = fpst_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = fpst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/fenwick_prefix_sum_table_top.sv
// Top level of the Fenwick prefix-sum table: handshakes, table memory, result register.
// Keeps 1024 signed 64-bit partial sums in one RAM (one write and one registered
// read port). After reset a clearing pass writes zero to every entry, with in_stall
// high throughout. An add request walks its climbing chain, one table read per entry,
// and produces no result; a query walks its descending chain, one read per set bit
// of its position, and loads one sum into the output register. The walk is bounded
// by the single RAM read port, which it uses once per cycle; in_stall stays high
// until the walk ends. A waiting result does not block the next request until that
// request's own sum is ready.
module fenwick_prefix_sum_table_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic [fpst_pkg::POS_W-1:0]        in_position,
  input  logic signed [fpst_pkg::SUM_W-1:0] in_increment,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fpst_pkg::SUM_W-1:0] out_prefix_sum
);

  fpst_pkg::mem_req_t         mem_req;
  fpst_pkg::res_t             res;
  logic [fpst_pkg::SUM_W-1:0] rd_data;
  logic                       seq_idle;
  logic                       seq_clearing;
  logic                       in_take;
  logic                       out_free;
  logic                       out_valid_r;
  logic [fpst_pkg::SUM_W-1:0] out_sum_r;

  assign in_stall = !seq_idle;
  assign in_take  = in_valid && seq_idle;
  assign out_free = !out_valid_r || !out_stall;

  fpst_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (in_take),
    .in_op    (in_op),
    .in_pos   (in_position),
    .in_inc   ($unsigned(in_increment)),
    .out_free (out_free),
    .rd_data  (rd_data),
    .idle     (seq_idle),
    .clearing (seq_clearing),
    .mem_req  (mem_req),
    .res      (res)
  );

  fpst_ram #(
    .DEPTH (fpst_pkg::TABLE_DEPTH),
    .WIDTH (fpst_pkg::SUM_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_sum_r <= res.sum;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_prefix_sum = $signed(out_sum_r);

  // Never read and write the same entry in one cycle: the chain addresses differ.
  assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("table read and write collide on one entry");

  // No request is taken while the clearing pass runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    seq_clearing |-> !in_take)
    else $error("request accepted during clearing pass");

  // A new sum never overwrites one that is still stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the Fenwick prefix-sum table: random requests, shadow table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1750;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam logic [fpst_pkg::SUM_W-1:0] SUM_MAX  = {1'b0, {(fpst_pkg::SUM_W-1){1'b1}}};
  localparam logic [fpst_pkg::SUM_W-1:0] SUM_MIN  = {1'b1, {(fpst_pkg::SUM_W-1){1'b0}}};
  localparam logic [fpst_pkg::SUM_W-1:0] SUM_ONES = {fpst_pkg::SUM_W{1'b1}};

  // Shadow copy of the partial-sum table and the queue of sums still owed.
  class fenwick_shadow;
    logic [fpst_pkg::SUM_W-1:0] sums [fpst_pkg::TABLE_DEPTH];
    logic [fpst_pkg::SUM_W-1:0] expected_sums [$];
    int failures;
    int adds;
    int adds_ignored;
    int queries_checked;

    function new();
      foreach (sums[i]) sums[i] = '0;
      failures = 0;
      adds = 0;
      adds_ignored = 0;
      queries_checked = 0;
    endfunction

    function void note_request(logic op, logic [fpst_pkg::POS_W-1:0] pos,
                               logic [fpst_pkg::SUM_W-1:0] inc);
      int unsigned p;
      logic [fpst_pkg::SUM_W-1:0] acc;
      p = 32'(pos);
      if (op == fpst_pkg::OP_ADD) begin
        adds++;
        if (p == 0 || p >= fpst_pkg::TABLE_DEPTH) begin
          adds_ignored++;
          return;
        end
        // climb: add the lowest set bit each step
        while (p < fpst_pkg::TABLE_DEPTH) begin
          sums[p] += inc;
          p += p & (~p + 1);
        end
      end else begin
        if (p >= fpst_pkg::TABLE_DEPTH) p = fpst_pkg::TABLE_DEPTH - 1;
        acc = '0;
        // descend: clear the lowest set bit each step
        while (p > 0) begin
          acc += sums[p];
          p &= p - 1;
        end
        expected_sums.push_back(acc);
      end
    endfunction

    function void check_sum(logic [fpst_pkg::SUM_W-1:0] actual);
      logic [fpst_pkg::SUM_W-1:0] want;
      if (expected_sums.size() == 0) begin
        $error("prefix_sum: expected none, actual %0d", $signed(actual));
        failures++;
        return;
      end
      want = expected_sums.pop_front();
      queries_checked++;
      if (actual !== want) begin
        $error("prefix_sum: expected %0d, actual %0d", $signed(want), $signed(actual));
        failures++;
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_op = fpst_pkg::OP_ADD;
  logic [fpst_pkg::POS_W-1:0]        in_position = '0;
  logic signed [fpst_pkg::SUM_W-1:0] in_increment = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [fpst_pkg::SUM_W-1:0] out_prefix_sum;

  fenwick_shadow shadow = new();
  int send_max_gap = 0;
  int recv_max_gap = 0;
  int long_hold = 0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  fenwick_prefix_sum_table_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_position    (in_position),
    .in_increment   (in_increment),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_prefix_sum (out_prefix_sum)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL fenwick_prefix_sum_table_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) shadow.check_sum(out_prefix_sum);
      if (in_valid && !in_stall) shadow.note_request(in_op, in_position, in_increment);
    end
  end

  // Result side: random stall before each result, or a long hold when asked.
  initial begin : result_sink
    int n;
    forever begin
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
      end else begin
        n = $urandom_range(0, recv_max_gap);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one request after a random gap; return at the edge that accepts it.
  task automatic issue(input logic op, input logic [fpst_pkg::POS_W-1:0] pos,
                       input logic [fpst_pkg::SUM_W-1:0] inc);
    int gap;
    gap = $urandom_range(0, send_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_position  <= pos;
    in_increment <= inc;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the input side until every owed sum has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (shadow.pending() != 0);
  endtask

  initial begin : stimulus
    int counted;
    int phase;
    int k;
    logic op;
    logic [fpst_pkg::POS_W-1:0] pos;
    logic [fpst_pkg::SUM_W-1:0] inc;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_max_gap = 3;
    recv_max_gap = 3;
    issue(fpst_pkg::OP_QUERY, 10'd0, SUM_ONES);
    issue(fpst_pkg::OP_QUERY, 10'd1023, '0);
    issue(fpst_pkg::OP_ADD, 10'd0, SUM_MAX);
    issue(fpst_pkg::OP_QUERY, 10'd1023, '0);
    issue(fpst_pkg::OP_ADD, 10'd1, SUM_MAX);
    issue(fpst_pkg::OP_ADD, 10'd1023, SUM_MIN);
    issue(fpst_pkg::OP_ADD, 10'd512, SUM_ONES);
    issue(fpst_pkg::OP_ADD, 10'd2, SUM_MAX);
    issue(fpst_pkg::OP_ADD, 10'd2, SUM_MAX);
    issue(fpst_pkg::OP_ADD, 10'd768, '0);
    issue(fpst_pkg::OP_QUERY, 10'd0, '0);
    issue(fpst_pkg::OP_QUERY, 10'd1, '0);
    issue(fpst_pkg::OP_QUERY, 10'd2, '0);
    issue(fpst_pkg::OP_QUERY, 10'd511, '0);
    issue(fpst_pkg::OP_QUERY, 10'd512, '0);
    issue(fpst_pkg::OP_QUERY, 10'd1022, '0);
    issue(fpst_pkg::OP_QUERY, 10'd1023, '0);
    issue(fpst_pkg::OP_ADD, 10'h155, 64'h5555_5555_5555_5555);
    issue(fpst_pkg::OP_ADD, 10'h2aa, 64'haaaa_aaaa_aaaa_aaaa);
    issue(fpst_pkg::OP_QUERY, 10'h2aa, '0);
    issue(fpst_pkg::OP_QUERY, 10'h155, '0);
    issue(fpst_pkg::OP_ADD, 10'd0, SUM_MIN);
    issue(fpst_pkg::OP_QUERY, 10'd1023, SUM_MAX);
    drain();

    // Long output hold with back-to-back requests so the block backs up.
    send_max_gap = 0;
    long_hold = HOLD_CYCLES;
    for (k = 0; k < 30; k++) begin
      op = ((k % 5) == 4) ? fpst_pkg::OP_ADD : fpst_pkg::OP_QUERY;
      issue(op, fpst_pkg::POS_W'($urandom_range(1, 1023)), {$urandom, $urandom});
    end
    drain();

    counted = 0;
    phase = 0;
    while (counted < RANDOM_ITEMS) begin
      case (phase % 4)
        0: begin send_max_gap = 18; recv_max_gap = 18; end
        1: begin send_max_gap = 0;  recv_max_gap = 0;  end
        2: begin send_max_gap = 2;  recv_max_gap = 18; end
        default: begin send_max_gap = 18; recv_max_gap = 0; end
      endcase
      for (k = 0; k < 150 && counted < RANDOM_ITEMS; k++) begin
        op = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 4))
              0: pos = '0;
              1: pos = 10'd1;
              2: pos = 10'd511;
              3: pos = 10'd512;
              default: pos = 10'd1023;
            endcase
          end
          1: pos = fpst_pkg::POS_W'(1) << $urandom_range(0, fpst_pkg::POS_W - 1);
          default: pos = fpst_pkg::POS_W'($urandom_range(0, 1023));
        endcase
        case ($urandom_range(0, 9))
          0: begin
            case ($urandom_range(0, 3))
              0: inc = SUM_MAX;
              1: inc = SUM_MIN;
              2: inc = SUM_ONES;
              default: inc = '0;
            endcase
          end
          1, 2, 3: inc = fpst_pkg::SUM_W'($signed($urandom_range(0, 200)) - 100);
          default: inc = {$urandom, $urandom};
        endcase
        issue(op, pos, inc);
        if (!(op == fpst_pkg::OP_ADD && pos == '0)) counted++;
      end
      if (phase % 2 == 1) drain();
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d add requests (%0d ignored) and %0d checked prefix sums,",
             shadow.adds, shadow.adds_ignored, shadow.queries_checked);
    $display("with random gaps on both sides, a %0d-cycle output hold and drain pauses.",
             HOLD_CYCLES);
    if (shadow.failures == 0 && shadow.pending() == 0) begin
      $display("PASS fenwick_prefix_sum_table_top");
    end else begin
      $display("FAIL fenwick_prefix_sum_table_top");
    end
    $finish;
  end

endmodule
